[hdl/utf8_stream_decoder_top_assert.svh]
// Assertion macros shared by the decoder top level.
`ifndef UTF8_STREAM_DECODER_TOP_ASSERT_SVH
`define UTF8_STREAM_DECODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8D_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U8D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/u8d_pkg.sv]
`timescale 1ns / 1ps

package u8d_pkg;

   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_END     = 2'd1,
      KIND_ILLEGAL = 2'd2,
      KIND_LIMIT   = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      CFG_CHAR_LIMIT = 1'b0,
      CFG_STORE_MODE = 1'b1
   } cfg_index_type;

   localparam logic [15:0] CHAR_LIMIT_RESET = 16'hFFFF;
   localparam logic        STORE_MODE_RESET = 1'b1;
   localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

   localparam logic [1:0] CONT_PREFIX  = 2'b10;
   localparam logic [2:0] LEAD2_PREFIX = 3'b110;
   localparam logic [3:0] LEAD3_PREFIX = 4'b1110;

   localparam int unsigned RSP_TDATA_W = 40;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       string_start;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] code_point;
      logic [15:0] char_count;
      logic        terminator_written;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } step_type;

endpackage

[hdl/utf8_stream_decoder_top.sv]
`timescale 1ns / 1ps
// UTF-8 stream decoder. Bytes of a NUL-terminated string enter on the req_ stream, one
// byte per beat, with req_tuser[0] set on the first byte of each string. Each byte
// that finishes a character, ends the string, breaks a sequence or hits the store
// limit produces one beat on the rsp_ stream; lead bytes and non-final continuation
// bytes of multibyte sequences, and bytes after a final beat, produce none. The final
// beat of a string carries rsp_tlast. A byte accepted on req_ lands in the input
// register, is decoded into the output register once that register can load, and
// is then offered on rsp_. One byte is taken every cycle while the receiver takes
// results; the rate is set by the single decode step between the input and output
// registers. When rsp_tready is low, the output register holds its beat, the input
// register holds one more byte, and req_tready then drops. The csr_ port writes
// char_limit (index 0) and store_mode (index 1); write only while the block is
// idle. Reset empties both registers, sets char_limit to 65535 and store_mode to 1,
// and leaves the decoder waiting for a string start.

module utf8_stream_decoder_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // data_byte
   input  logic [0:0]                         req_tuser,  // string_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // code_point[15:0], char_count[31:16], terminator_written[32], zero fill
   output logic [u8d_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [1:0]                         rsp_tuser,  // kind
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [0:0]                         csr_index,
   input  logic [15:0]                        csr_wdata
);

`include "utf8_stream_decoder_top_assert.svh"

   u8d_pkg::req_type  req_item;
   u8d_pkg::req_type  item;
   u8d_pkg::step_type result;
   u8d_pkg::rsp_type  rsp;
   logic              item_valid;
   logic              can_load;
   logic              step;

   assign req_item.data_byte    = req_tdata;
   assign req_item.string_start = req_tuser[0];
   assign step                  = item_valid && can_load;

   u8d_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   u8d_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step),
      .item      (item),
      .result    (result)
   );

   u8d_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .can_load  (can_load),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {7'd0, rsp.terminator_written, rsp.char_count, rsp.code_point};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

   `U8D_ASSERT_SAME(a_last_matches_kind, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tuser != u8d_pkg::KIND_CHAR), "tlast disagrees with kind")
   `U8D_ASSERT_SAME(a_code_zero_on_final, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[15:0] == 16'd0, "code point not zero on a final beat")
   `U8D_ASSERT_SAME(a_term_only_on_end, clock, reset, rsp_tvalid && rsp_tdata[32], rsp_tuser == u8d_pkg::KIND_END, "terminator flag outside end of string")
   `U8D_ASSERT_NEXT(a_step_fills_output, clock, reset, result.valid, rsp_tvalid && (rsp_tuser == $past(result.rsp.kind)), "decoded result not registered")

endmodule

[hdl/u8d_in_stage.sv]
`timescale 1ns / 1ps

module u8d_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  u8d_pkg::req_type  req_item,
   input  logic              take,
   output logic              item_valid,
   output u8d_pkg::req_type  item
);

   logic             valid_ff;
   logic             valid_in;
   u8d_pkg::req_type item_ff;
   logic             accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hdl/u8d_core.sv]
`timescale 1ns / 1ps

module u8d_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   input  logic              step,
   input  u8d_pkg::req_type  item,
   output u8d_pkg::step_type result
);

   logic [15:0] char_limit_ff;
   logic        store_mode_ff;
   logic [1:0]  pending_ff;
   logic [1:0]  pending_in;
   logic [15:0] partial_ff;
   logic [15:0] partial_in;
   logic [15:0] converted_ff;
   logic [15:0] converted_in;
   logic        finished_ff;
   logic        finished_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         char_limit_ff <= u8d_pkg::CHAR_LIMIT_RESET;
         store_mode_ff <= u8d_pkg::STORE_MODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            u8d_pkg::CFG_CHAR_LIMIT: char_limit_ff <= csr_wdata;
            u8d_pkg::CFG_STORE_MODE: store_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [7:0]  b;
      logic [1:0]  pend;
      logic [1:0]  pend_dec;
      logic [15:0] part;
      logic [15:0] merged;
      logic [15:0] conv;
      logic [15:0] cp;
      logic        fin;
      logic        do_complete;
      logic        do_illegal;

      b    = item.data_byte;
      pend = item.string_start ? 2'd0  : pending_ff;
      part = item.string_start ? 16'd0 : partial_ff;
      conv = item.string_start ? 16'd0 : converted_ff;
      fin  = item.string_start ? 1'b0  : finished_ff;

      pend_dec    = pend - 2'd1;
      merged      = part | (pend_dec[0] ? {4'd0, b[5:0], 6'd0} : {10'd0, b[5:0]});
      cp          = 16'd0;
      do_complete = 1'b0;
      do_illegal  = 1'b0;

      pending_in   = pend;
      partial_in   = part;
      converted_in = conv;
      finished_in  = fin;

      result                         = '0;
      result.rsp.kind                = u8d_pkg::KIND_CHAR;
      result.rsp.char_count          = conv;

      if (!fin) begin
         if (pend != 2'd0) begin
            if (b[7:6] != u8d_pkg::CONT_PREFIX) begin
               do_illegal = 1'b1;
            end else if (pend_dec != 2'd0) begin
               pending_in = pend_dec;
               partial_in = merged;
            end else begin
               pending_in  = 2'd0;
               partial_in  = 16'd0;
               cp          = merged;
               do_complete = 1'b1;
            end
         end else if (b == 8'd0) begin
            result.valid                  = 1'b1;
            result.rsp.kind               = u8d_pkg::KIND_END;
            result.rsp.terminator_written = store_mode_ff && (conv < char_limit_ff);
            result.rsp.last               = 1'b1;
            finished_in                   = 1'b1;
         end else if (!b[7]) begin
            cp          = {8'd0, b};
            do_complete = 1'b1;
         end else if (b[7:5] == u8d_pkg::LEAD2_PREFIX) begin
            pending_in = 2'd1;
            partial_in = {5'd0, b[4:0], 6'd0};
         end else if (b[7:4] == u8d_pkg::LEAD3_PREFIX) begin
            pending_in = 2'd2;
            partial_in = {b[3:0], 12'd0};
         end else begin
            do_illegal = 1'b1;
         end
      end

      if (do_illegal) begin
         result.valid    = 1'b1;
         result.rsp.kind = u8d_pkg::KIND_ILLEGAL;
         result.rsp.last = 1'b1;
         finished_in     = 1'b1;
         pending_in      = 2'd0;
         partial_in      = 16'd0;
      end

      if (do_complete) begin
         result.valid = 1'b1;
         if (store_mode_ff && (conv >= char_limit_ff)) begin
            result.rsp.kind = u8d_pkg::KIND_LIMIT;
            result.rsp.last = 1'b1;
            finished_in     = 1'b1;
         end else begin
            if (store_mode_ff || (conv != u8d_pkg::COUNT_MAX)) begin
               converted_in = conv + 16'd1;
            end
            result.rsp.code_point = cp;
            result.rsp.char_count = converted_in;
         end
      end

      result.valid = result.valid && step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 2'd0;
         partial_ff   <= 16'd0;
         converted_ff <= 16'd0;
         finished_ff  <= 1'b1;
      end else if (step) begin
         pending_ff   <= pending_in;
         partial_ff   <= partial_in;
         converted_ff <= converted_in;
         finished_ff  <= finished_in;
      end
   end

endmodule

[hdl/u8d_out_stage.sv]
`timescale 1ns / 1ps

module u8d_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  u8d_pkg::step_type result,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output u8d_pkg::rsp_type  rsp
);

   logic             valid_ff;
   logic             valid_in;
   u8d_pkg::rsp_type rsp_ff;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      if (result.valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_ff <= result.rsp;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule
